/* rtl/mlpr_pkg.sv */
// ----------------------------------------------------------------------------
// mlpr_pkg
// shared types and constants of the perceptron inference engine
// ----------------------------------------------------------------------------
package mlpr_pkg;

  // item kinds carried on s_tuser
  localparam logic [1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [1:0] CMD_BIAS    = 2'd1;
  localparam logic [1:0] CMD_FEATURE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_IN_SIZE = 2'd0;
  localparam logic [1:0] REG_H1_SIZE = 2'd1;
  localparam logic [1:0] REG_H2_SIZE = 2'd2;
  localparam logic [1:0] REG_OUT_SIZE = 2'd3;

  localparam int IDX_W  = 6;   // neuron index width
  localparam int CNT_W  = 7;   // sizes and counters
  localparam int DATA_W = 32;  // q16.16
  localparam int ACC_W  = 56;  // 48-bit terms, up to 64 of them plus bias

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             relu;
    logic [IDX_W-1:0] idx;
  } mac_ctl_t;

endpackage

/* rtl/mlpr_ram.sv */
// ----------------------------------------------------------------------------
// mlpr_ram
// simple dual-port memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module mlpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/mlpr_mac.sv */
// ----------------------------------------------------------------------------
// mlpr_mac
// multiply-accumulate pipeline: product, floor shift, bias, saturate, relu
// ----------------------------------------------------------------------------
module mlpr_mac
  import mlpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mac_ctl_t          ctl,
  input  logic [DATA_W-1:0] act_data,
  input  logic [DATA_W-1:0] weight_data,
  input  logic [DATA_W-1:0] bias_data,
  output logic              res_valid,
  output logic [IDX_W-1:0]  res_idx,
  output logic [DATA_W-1:0] res_value,
  output logic              busy
);

  mac_ctl_t ctl1, ctl2, ctl3;
  logic signed [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]          bias2;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_next;
  logic signed [2*DATA_W-17:0] term;
  logic                       ovf;
  logic [DATA_W-1:0]          sat;

  // arithmetic shift of the product is the floor of the division by 2^16
  assign term = prod[2*DATA_W-1:16];

  always_comb begin
    acc_next = ctl2.first ? ACC_W'(signed'(bias2)) : acc;
    acc_next = acc_next + ACC_W'(term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else begin
      ctl1 <= ctl;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
    end
    prod  <= signed'(act_data) * signed'(weight_data);
    bias2 <= bias_data;
    if (ctl2.valid) begin
      acc <= acc_next;
    end
  end

  assign ovf = (acc[ACC_W-1:DATA_W-1] != '0) && (acc[ACC_W-1:DATA_W-1] != '1);

  always_comb begin
    if (ovf) begin
      sat = acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat = acc[DATA_W-1:0];
    end
    if (ctl3.relu && sat[DATA_W-1]) begin
      sat = '0;
    end
  end

  assign res_valid = ctl3.valid && ctl3.last;
  assign res_idx   = ctl3.idx;
  assign res_value = sat;
  assign busy      = ctl1.valid || ctl2.valid || ctl3.valid;

endmodule

/* rtl/mlp_relu_inference.sv */
// ----------------------------------------------------------------------------
// mlp_relu_inference
// three-layer perceptron forward pass, relu on hidden layers
// ----------------------------------------------------------------------------
// usage:
//   s_* stream carries items: s_tuser selects weight write, bias write or
//   feature element; s_tlast marks the last feature and starts a pass.
//   weight and bias writes and non-last features are taken one per cycle.
//   the last feature is taken, then s_tready stays low while the pass runs:
//   per layer one multiply-accumulate per weight (one weight memory read
//   per cycle), then a pipeline drain; then the output results are read
//   back one at a time from the activation memory, each before it is sent.
//   a count mismatch or a bad in_size gives one error result (status 1) instead.
//   m_* stream carries results through one output register; a stalled
//   receiver holds the result and pauses readout. loads may still be
//   taken while the last result waits.
//   apb port writes and reads the four size registers.
//   reset clears control state and returns the sizes to 13, 64, 64 and 8;
//   memories are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module mlp_relu_inference
  import mlpr_pkg::*;
#(
  parameter int MAX_NEURONS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // layer_select[1:0], from_index[7:2], to_index[13:8],
                                 // value[45:14], zero fill
  input  logic [1:0]  s_tuser,   // command
  input  logic        s_tlast,   // last_element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_index[5:0], out_value[37:6], zero fill
  output logic        m_tuser,   // status
  output logic        m_tlast,   // last_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LIM  = (MAX_NEURONS < 64) ? MAX_NEURONS : 64;
  localparam int WD   = 3 * MAX_NEURONS * MAX_NEURONS;
  localparam int BD   = 3 * MAX_NEURONS;
  localparam int AD   = 2 * LIM;
  localparam int WAW  = $clog2(WD);
  localparam int BAW  = $clog2(BD);
  localparam int AAW  = $clog2(AD);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ERR, ST_ISSUE, ST_DRAIN, ST_EMIT_RD, ST_EMIT_WAIT
  } state_t;

  state_t state;

  // size registers
  logic [CNT_W-1:0] in_size, h1_size, h2_size, out_size;
  logic [CNT_W-1:0] feature_count;

  // walk counters
  logic [1:0]       layer;
  logic [CNT_W-1:0] i_cnt, j_cnt, n_in, n_out;

  // input fields
  logic [1:0]        f_layer;
  logic [IDX_W-1:0]  f_from, f_to;
  logic [DATA_W-1:0] f_value;
  assign f_layer = s_tdata[1:0];
  assign f_from  = s_tdata[7:2];
  assign f_to    = s_tdata[13:8];
  assign f_value = s_tdata[45:14];

  logic s_fire;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // apb
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_IN_SIZE:  prdata = 32'(in_size);
      REG_H1_SIZE:  prdata = 32'(h1_size);
      REG_H2_SIZE:  prdata = 32'(h2_size);
      REG_OUT_SIZE: prdata = 32'(out_size);
      default:      prdata = '0;
    endcase
  end

  function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] s);
    if (s == '0) return CNT_W'(1);
    if (s > CNT_W'(LIM)) return CNT_W'(LIM);
    return s;
  endfunction

  // weight and bias memories
  logic             w_we, b_we;
  logic [WAW-1:0]   w_waddr, w_raddr;
  logic [BAW-1:0]   b_waddr, b_raddr;
  logic [DATA_W-1:0] w_rdata, b_rdata;

  assign w_we = s_fire && (s_tuser == CMD_WEIGHT) && (f_layer != 2'd3)
                && (CNT_W'(f_from) < CNT_W'(LIM)) && (CNT_W'(f_to) < CNT_W'(LIM));
  assign b_we = s_fire && (s_tuser == CMD_BIAS) && (f_layer != 2'd3)
                && (CNT_W'(f_to) < CNT_W'(LIM));
  assign w_waddr = WAW'(f_layer) * WAW'(MAX_NEURONS * MAX_NEURONS)
                 + WAW'(f_from) * WAW'(MAX_NEURONS) + WAW'(f_to);
  assign b_waddr = BAW'(f_layer) * BAW'(MAX_NEURONS) + BAW'(f_to);
  assign w_raddr = WAW'(layer) * WAW'(MAX_NEURONS * MAX_NEURONS)
                 + WAW'(i_cnt) * WAW'(MAX_NEURONS) + WAW'(j_cnt);
  assign b_raddr = BAW'(layer) * BAW'(MAX_NEURONS) + BAW'(j_cnt);

  mlpr_ram #(.WIDTH(DATA_W), .DEPTH(WD)) u_wmem (
    .clk(clk), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(f_value),
    .rd_addr(w_raddr), .rd_data(w_rdata)
  );

  mlpr_ram #(.WIDTH(DATA_W), .DEPTH(BD)) u_bmem (
    .clk(clk), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(f_value),
    .rd_addr(b_raddr), .rd_data(b_rdata)
  );

  // activation memory: bank 0 in the low half, bank 1 in the high half
  logic              res_valid, mac_busy;
  logic [IDX_W-1:0]  res_idx;
  logic [DATA_W-1:0] res_value;
  logic              a_we;
  logic [AAW-1:0]    a_waddr, a_raddr;
  logic [DATA_W-1:0] a_wdata, a_rdata;
  logic              feat_we;
  logic              src_bank;

  assign src_bank = layer[0];
  assign feat_we  = s_fire && (s_tuser == CMD_FEATURE) && (feature_count < CNT_W'(LIM));

  always_comb begin
    if (res_valid) begin
      a_we    = 1'b1;
      a_waddr = src_bank ? AAW'(res_idx) : AAW'(LIM) + AAW'(res_idx);
      a_wdata = res_value;
    end else begin
      a_we    = feat_we;
      a_waddr = AAW'(feature_count);
      a_wdata = f_value;
    end
    if (state == ST_ISSUE) begin
      a_raddr = src_bank ? AAW'(LIM) + AAW'(i_cnt) : AAW'(i_cnt);
    end else begin
      a_raddr = AAW'(LIM) + AAW'(j_cnt);  // output layer results sit in bank 1
    end
  end

  mlpr_ram #(.WIDTH(DATA_W), .DEPTH(AD)) u_amem (
    .clk(clk), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(a_wdata),
    .rd_addr(a_raddr), .rd_data(a_rdata)
  );

  // mac pipeline
  mac_ctl_t ctl;
  always_comb begin
    ctl.valid = (state == ST_ISSUE);
    ctl.first = (i_cnt == '0);
    ctl.last  = (i_cnt == n_in - CNT_W'(1));
    ctl.relu  = (layer != 2'd2);
    ctl.idx   = j_cnt[IDX_W-1:0];
  end

  mlpr_mac u_mac (
    .clk(clk), .rst(rst), .ctl(ctl),
    .act_data(a_rdata), .weight_data(w_rdata), .bias_data(b_rdata),
    .res_valid(res_valid), .res_idx(res_idx), .res_value(res_value),
    .busy(mac_busy)
  );

  logic [CNT_W-1:0] fc_inc;
  logic             out_free;
  logic             out_load;
  assign fc_inc   = (feature_count < CNT_W'(127)) ? feature_count + CNT_W'(1) : feature_count;
  assign out_free = !m_tvalid || m_tready;
  // a new result item enters the output register this cycle
  assign out_load = out_free && ((state == ST_ERR) || (state == ST_EMIT_WAIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      in_size       <= CNT_W'(13);
      h1_size       <= CNT_W'(64);
      h2_size       <= CNT_W'(64);
      out_size      <= CNT_W'(8);
      feature_count <= '0;
      layer         <= '0;
      i_cnt         <= '0;
      j_cnt         <= '0;
      n_in          <= '0;
      n_out         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_IN_SIZE:  in_size  <= pwdata[CNT_W-1:0];
          REG_H1_SIZE:  h1_size  <= pwdata[CNT_W-1:0];
          REG_H2_SIZE:  h2_size  <= pwdata[CNT_W-1:0];
          REG_OUT_SIZE: out_size <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_fire && (s_tuser == CMD_FEATURE)) begin
            if (s_tlast) begin
              feature_count <= '0;
              if (in_size == '0 || in_size > CNT_W'(LIM) || fc_inc != in_size) begin
                state <= ST_ERR;
              end else begin
                state <= ST_ISSUE;
                layer <= 2'd0;
                i_cnt <= '0;
                j_cnt <= '0;
                n_in  <= in_size;
                n_out <= clamp_size(h1_size);
              end
            end else begin
              feature_count <= fc_inc;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_ISSUE: begin
          if (i_cnt == n_in - CNT_W'(1)) begin
            i_cnt <= '0;
            if (j_cnt == n_out - CNT_W'(1)) begin
              state <= ST_DRAIN;
            end else begin
              j_cnt <= j_cnt + CNT_W'(1);
            end
          end else begin
            i_cnt <= i_cnt + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          // wait for the last neuron to be written back before reading it
          if (!mac_busy) begin
            j_cnt <= '0;
            i_cnt <= '0;
            if (layer == 2'd2) begin
              state <= ST_EMIT_RD;
            end else begin
              state <= ST_ISSUE;
              layer <= layer + 2'd1;
              n_in  <= n_out;
              n_out <= (layer == 2'd0) ? clamp_size(h2_size) : clamp_size(out_size);
            end
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, a_rdata, j_cnt[IDX_W-1:0]};
            m_tuser  <= 1'b0;
            m_tlast  <= (j_cnt == n_out - CNT_W'(1));
            if (j_cnt == n_out - CNT_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              j_cnt <= j_cnt + CNT_W'(1);
              state <= ST_EMIT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* verif/tb_mlp_relu_inference.sv */
// ----------------------------------------------------------------------------
// tb_mlp_relu_inference
// self-checking bench for the three-layer perceptron inference engine
// ----------------------------------------------------------------------------
// loads weights and biases, streams feature runs and compares every result
// item against a behavioural q16.16 forward pass kept in the bench. sizes
// are set over apb and read back. both stream sides idle at random, and
// the receiver holds off once for a long stretch so that input stalls.
// ----------------------------------------------------------------------------
module tb_mlp_relu_inference;
  import mlpr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX       = 64;
  localparam int CYCLE_CAP  = 2000000;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_WAIT = 40;

  // unknown command, not defined in the package
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] val;
    logic        st;
    logic        lst;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // layer_select, from_index, to_index, value, zero fill
  logic [1:0]  s_tuser = CMD_WEIGHT;  // command
  logic        s_tlast = 1'b0; // last_element
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // out_index, out_value, zero fill
  logic        m_tuser;        // status
  logic        m_tlast;        // last_result
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mlp_relu_inference DUT (.*);

  always #5 clk = ~clk;

  // bench copy of the engine state
  logic signed [31:0] weight_mem [0:3*NMAX*NMAX-1];
  bit                 weight_set [0:3*NMAX*NMAX-1];
  logic signed [31:0] bias_mem   [0:3*NMAX-1];
  bit                 bias_set   [0:3*NMAX-1];
  logic signed [31:0] act_a [0:NMAX-1];
  logic signed [31:0] act_b [0:NMAX-1];
  logic signed [31:0] act_tmp [0:NMAX-1];
  int                 feat_count;
  int                 size_reg [0:3];

  result_t pending_outputs [$];
  int      err_count;
  int      cycles;
  bit      no_idle;
  bit      hold_req;
  int      rx_wait;

  // ---------------------------------------------------------------- predictor

  function automatic int eff_size(int s);
    if (s < 1) return 1;
    if (s > NMAX) return NMAX;
    return s;
  endfunction

  // one fully connected layer; from_a picks act_a as the source
  function automatic void run_layer(int layer, int n_in, int n_out, bit relu, bit from_a);
    longint acc;
    longint p;
    logic signed [31:0] s;
    for (int j = 0; j < n_out; j++) begin
      acc = 0;
      for (int i = 0; i < n_in; i++) begin
        s = from_a ? act_a[i] : act_b[i];
        p = longint'(s) * longint'(weight_mem[(layer*NMAX + i)*NMAX + j]);
        acc += p >>> 16;  // floor shift
      end
      acc += longint'(bias_mem[layer*NMAX + j]);
      if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
      if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
      if (relu && acc < 0) acc = 0;
      act_tmp[j] = acc[31:0];
    end
    for (int j = 0; j < n_out; j++)
      if (from_a) act_b[j] = act_tmp[j];
      else act_a[j] = act_tmp[j];
  endfunction

  function automatic void predict_item(logic [1:0] cmd, logic [1:0] layer, logic [5:0] from_i,
                                       logic [5:0] to_i, logic [31:0] val, logic last);
    int h1, h2, no;
    result_t r;
    case (cmd)
      CMD_WEIGHT: if (layer != 2'd3) begin
        weight_mem[(layer*NMAX + from_i)*NMAX + to_i] = val;
        weight_set[(layer*NMAX + from_i)*NMAX + to_i] = 1'b1;
      end
      CMD_BIAS: if (layer != 2'd3) begin
        bias_mem[layer*NMAX + to_i] = val;
        bias_set[layer*NMAX + to_i] = 1'b1;
      end
      CMD_FEATURE: begin
        if (feat_count < NMAX) act_a[feat_count] = val;
        if (feat_count < 127) feat_count++;
        if (last) begin
          if (size_reg[REG_IN_SIZE] < 1 || size_reg[REG_IN_SIZE] > NMAX ||
              feat_count != size_reg[REG_IN_SIZE]) begin
            r = '{idx: '0, val: '0, st: 1'b1, lst: 1'b1};
            pending_outputs = {pending_outputs, r};
          end else begin
            h1 = eff_size(size_reg[REG_H1_SIZE]);
            h2 = eff_size(size_reg[REG_H2_SIZE]);
            no = eff_size(size_reg[REG_OUT_SIZE]);
            run_layer(0, size_reg[REG_IN_SIZE], h1, 1'b1, 1'b1);
            run_layer(1, h1, h2, 1'b1, 1'b0);
            run_layer(2, h2, no, 1'b0, 1'b1);
            for (int j = 0; j < no; j++) begin
              r = '{idx: j[5:0], val: act_b[j], st: 1'b0, lst: (j == no-1)};
              pending_outputs = {pending_outputs, r};
            end
          end
          feat_count = 0;
        end
      end
      default: ;  // unknown command is dropped
    endcase
  endfunction

  // ------------------------------------------------------------- result check

  // receiver side: per-item random hold-off, plus one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      m_tready <= 1'b0;
      repeat (LONG_HOLD) @(negedge clk);
      hold_req = 1'b0;
    end else if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_tready <= !rst;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      rx_wait = no_idle ? 0 : $urandom_range(0, 12);
      if (pending_outputs.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("result item with nothing pending: idx %0d val %h st %b last %b",
                   m_tdata[5:0], m_tdata[37:6], m_tuser, m_tlast);
      end else begin
        want = pending_outputs.pop_front();
        if (m_tdata[5:0] !== want.idx || m_tdata[37:6] !== want.val ||
            m_tuser !== want.st || m_tlast !== want.lst) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected idx %0d val %h st %b last %b, got idx %0d val %h st %b last %b",
                     want.idx, want.val, want.st, want.lst,
                     m_tdata[5:0], m_tdata[37:6], m_tuser, m_tlast);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ------------------------------------------------------------ stimulus side

  // entered and left at a falling edge; valid stays high into the next item unless a gap is drawn
  task automatic send_item(logic [1:0] cmd, logic [1:0] layer, logic [5:0] from_i,
                           logic [5:0] to_i, logic [31:0] val, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {2'b00, val, to_i, from_i, layer};
    s_tuser  <= cmd;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_item(cmd, layer, from_i, to_i, val, last);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;  // about +-2.0
    endcase
  endfunction

  // wait for all result items, then for the engine to settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // apb write then read back
  task automatic cfg_write(logic [1:0] idx, int val);
    wait_idle();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    size_reg[idx] = val & 8'h7F;
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(size_reg[idx])) begin
      err_count++;
      if (err_count <= 10)
        $display("register %0d readback: expected %h got %h", idx, size_reg[idx], prdata);
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_sizes(int in_s, int h1, int h2, int no);
    cfg_write(REG_IN_SIZE, in_s);
    cfg_write(REG_H1_SIZE, h1);
    cfg_write(REG_H2_SIZE, h2);
    cfg_write(REG_OUT_SIZE, no);
  endtask

  // writes every weight and bias the current sizes use and that is still unset
  task automatic fill_network();
    int n [0:3];
    n[0] = eff_size(size_reg[REG_IN_SIZE]);
    n[1] = eff_size(size_reg[REG_H1_SIZE]);
    n[2] = eff_size(size_reg[REG_H2_SIZE]);
    n[3] = eff_size(size_reg[REG_OUT_SIZE]);
    for (int l = 0; l < 3; l++)
      for (int t = 0; t < n[l+1]; t++) begin
        if (!bias_set[l*NMAX + t])
          send_item(CMD_BIAS, l[1:0], 6'($urandom()), t[5:0], rand_q16(), 1'($urandom()));
        for (int f = 0; f < n[l]; f++)
          if (!weight_set[(l*NMAX + f)*NMAX + t])
            send_item(CMD_WEIGHT, l[1:0], f[5:0], t[5:0], rand_q16(), 1'b0);
      end
  endtask

  // a run of count features, the last one flagged
  task automatic send_features(int count);
    for (int k = 1; k <= count; k++)
      send_item(CMD_FEATURE, 2'($urandom()), 6'($urandom()), 6'($urandom()),
                rand_q16(), k == count);
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_reset_values();
    int want [0:3];
    want = '{13, 64, 64, 8};
    for (int i = 0; i < 4; i++) begin
      psel <= 1'b1; pwrite <= 1'b0; paddr <= 4'(i*4);
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      if (prdata !== 32'(want[i])) begin
        err_count++;
        if (err_count <= 10)
          $display("reset value of register %0d: expected %0d got %0d", i, want[i], prdata);
      end
      @(negedge clk);
      psel <= 1'b0; penable <= 1'b0;
      @(negedge clk);
    end
  endtask

  // smallest network, extreme feature values, saturation
  task automatic test_directed();
    set_sizes(1, 1, 1, 1);
    fill_network();
    send_item(CMD_WEIGHT, 2'd0, 6'd0, 6'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(CMD_FEATURE, 2'd0, 6'd0, 6'd0, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_FEATURE, 2'd3, 6'd63, 6'd63, 32'h8000_0000, 1'b1);
    // unknown command and layer select 3 change nothing
    send_item(CMD_NONE, 2'd0, 6'd0, 6'd0, 32'h0, 1'b1);
    send_item(CMD_WEIGHT, 2'd3, 6'd0, 6'd0, 32'h1234_5678, 1'b0);
    send_item(CMD_BIAS, 2'd3, 6'd63, 6'd0, 32'h8765_4321, 1'b0);
    send_item(CMD_WEIGHT, 2'd2, 6'd0, 6'd0, 32'h8000_0000, 1'b0);
    send_item(CMD_BIAS, 2'd2, 6'd0, 6'd0, 32'h8000_0000, 1'b0);
    send_features(1);
    // count mismatch: too many, then too few
    send_features(3);
    set_sizes(2, 1, 1, 1);
    fill_network();
    send_features(1);
    send_features(2);
    // in_size zero and out of range
    cfg_write(REG_IN_SIZE, 0);
    send_features(1);
    cfg_write(REG_IN_SIZE, 127);
    send_features(2);
  endtask

  // layer size registers outside 1..64 are clamped
  task automatic test_clamped_sizes();
    set_sizes(1, 0, 127, 0);
    fill_network();
    send_features(1);
    set_sizes(2, 1, 0, 65);
    fill_network();
    send_features(2);
  endtask

  // count beyond the limit saturates and gives an error result
  task automatic test_feature_overflow();
    set_sizes(64, 2, 2, 2);
    no_idle = 1'b1;
    send_features(130);
    no_idle = 1'b0;
  endtask

  // input run at its top length
  task automatic test_widest_input();
    set_sizes(64, 1, 1, 1);
    no_idle = 1'b1;
    fill_network();
    no_idle = 1'b0;
    send_features(64);
  endtask

  // receiver stops for a long time while passes keep arriving
  task automatic test_output_stall();
    set_sizes(4, 3, 1, 64);
    fill_network();
    hold_req = 1'b1;
    send_features(4);
    send_item(CMD_WEIGHT, 2'd1, 6'd1, 6'd2, rand_q16(), 1'b0);
    send_item(CMD_BIAS, 2'd2, 6'd0, 6'd5, rand_q16(), 1'b0);
    send_features(4);
    send_features(4);
  endtask

  // mostly well-formed runs with random content, some broken runs and noise
  task automatic test_random();
    int sent;
    int len;
    int in_s;
    sent = 0;
    while (sent < 100) begin
      if ($urandom_range(0, 3) == 0) begin
        in_s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
        set_sizes(in_s, $urandom_range(0, 6), $urandom_range(1, 6), $urandom_range(1, 8));
        fill_network();
      end
      repeat ($urandom_range(5, 20)) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(2'($urandom_range(0, 3)), 2'($urandom()), 6'($urandom()), 6'($urandom()),
                    $urandom(), 1'($urandom()));
        end else begin
          in_s = eff_size(size_reg[REG_IN_SIZE]);
          len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, in_s + 3) : in_s;
          send_features(len);
          sent += len;
        end
        sent++;
      end
    end
  endtask

  initial begin
    feat_count = 0;
    err_count  = 0;
    cycles     = 0;
    rx_wait    = 0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    size_reg   = '{13, 64, 64, 8};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_directed();
    test_clamped_sizes();
    test_feature_overflow();
    test_widest_input();
    test_output_stall();
    test_random();

    wait_idle();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* mlp_relu_inference.f */
rtl/mlpr_pkg.sv
rtl/mlpr_ram.sv
rtl/mlpr_mac.sv
rtl/mlp_relu_inference.sv
verif/tb_mlp_relu_inference.sv
